[hw/rtl/pep_pkg.sv]
// pep_pkg: sizes, status and action codes, beat types and the candidate merge
// shared by the task picker. No dependencies.
`timescale 1ns / 1ps

package pep_pkg;

    // Table geometry
    localparam int NUM_SLOTS  = 1024;
    localparam int PRIO_BITS  = 8;
    localparam int NUM_CELLS  = 4;
    localparam int CELL_BITS  = $clog2(NUM_CELLS);
    localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
    localparam int BANK_DEPTH = (NUM_SLOTS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IDX_W      = BANK_AW + CELL_BITS;
    localparam int STAT_W     = 3;
    localparam int WORD_W     = STAT_W + PRIO_BITS;

    // Fixed field widths on the ports
    localparam int SLOT_FW = 10;
    localparam int PRIO_FW = 8;
    localparam int ACT_W   = 2;

    // Drain of the cell chain after the last read: covers the RAM read register and one token register per cell
    localparam int DRAIN_CYCLES = NUM_CELLS + 1;
    localparam int CNT_W        = $clog2(DRAIN_CYCLES + 1);

    localparam logic [PRIO_BITS-1:0] PRIO_MAX = '1;

    // Commands (carried on tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_YIELD = 1'b1;

    // Slot status codes
    localparam logic [STAT_W-1:0] ST_FREE         = 3'd0;
    localparam logic [STAT_W-1:0] ST_DYING        = 3'd1;
    localparam logic [STAT_W-1:0] ST_RUNNABLE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_RUNNING      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_RUNNABLE = 3'd4;

    // Decisions
    localparam logic [ACT_W-1:0] ACT_RUN     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_HALT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MONITOR = 2'd2;

    // Best-so-far record handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [PRIO_BITS-1:0] prio;
        logic [SLOT_BITS-1:0] pos;     // distance from the scan start
        logic [SLOT_BITS-1:0] idx;
        logic                 live;    // some slot runnable, running or dying
        logic                 cur_run; // current slot seen in running state
    } cand_t;

    localparam cand_t CAND_EMPTY = '0;

    // Table write, from a write beat or the clearing pass
    typedef struct packed {
        logic                 en;
        logic                 all;
        logic [CELL_BITS-1:0] bank;
        logic [BANK_AW-1:0]   addr;
        logic [WORD_W-1:0]    word;
    } ram_wr_t;

    // Scan control broadcast to every cell
    typedef struct packed {
        logic                 rd_en;
        logic [BANK_AW-1:0]   rd_addr;
        logic                 smp_vld;
        logic [BANK_AW-1:0]   smp_k;
        logic                 has_cur;
        logic [SLOT_BITS-1:0] cur;
        logic [SLOT_BITS-1:0] start;
    } scan_t;

    // Keep the lower (priority, scan position) key; the flags accumulate.
    // The key order does not depend on visit order, so the first slot met
    // wins a tie however the cells visit the table.
    function automatic cand_t cand_merge(cand_t a, cand_t b);
        cand_t r;
        logic  a_wins;
        a_wins    = a.valid && (!b.valid || ({a.prio, a.pos} < {b.prio, b.pos}));
        r         = a_wins ? a : b;
        r.live    = a.live | b.live;
        r.cur_run = a.cur_run | b.cur_run;
        return r;
    endfunction

endpackage

[hw/rtl/pep_ram.sv]
// pep_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pep_cell.sv]
// pep_cell: one cell of the scan chain. Owns one bank of the slot table,
// weighs one entry per cycle and passes the best record on.
// Depends on pep_pkg and pep_ram.
`timescale 1ns / 1ps

module pep_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pep_pkg::CELL_BITS-1:0] cell_id,
    input  pep_pkg::ram_wr_t          wr,
    input  pep_pkg::scan_t            scan,
    input  pep_pkg::cand_t            tok_in,
    output pep_pkg::cand_t            tok_out
);
    import pep_pkg::*;

    logic [WORD_W-1:0]    rdata;
    logic                 we;
    logic [STAT_W-1:0]    stat;
    logic [PRIO_BITS-1:0] prio;
    logic [IDX_W-1:0]     idx_full;
    logic [SLOT_BITS-1:0] idx;
    logic                 in_range;
    logic [SLOT_BITS:0]   diff;
    logic [SLOT_BITS-1:0] pos;
    cand_t                local_c;
    cand_t                tok_reg;
    cand_t                tok_next;

    // Bank storage; slot index is {bank address, cell id}
    assign we = wr.en && (wr.all || (wr.bank == cell_id));

    pep_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr.addr),
        .wdata (wr.word),
        .re    (scan.rd_en),
        .raddr (scan.rd_addr),
        .rdata (rdata)
    );

    // Decode the sampled entry
    always_comb begin
        stat     = rdata[WORD_W-1 -: STAT_W];
        prio     = rdata[PRIO_BITS-1:0];
        idx_full = {scan.smp_k, cell_id};
        in_range = (32'(idx_full) < NUM_SLOTS);
        idx      = SLOT_BITS'(idx_full);
        // circular distance from the scan start
        diff     = {1'b0, idx} - {1'b0, scan.start};
        if (diff[SLOT_BITS]) begin
            pos = SLOT_BITS'(diff + (SLOT_BITS + 1)'(NUM_SLOTS));
        end else begin
            pos = diff[SLOT_BITS-1:0];
        end
    end

    // Local candidate, empty when no entry is sampled
    always_comb begin
        local_c = CAND_EMPTY;
        if (scan.smp_vld && in_range) begin
            local_c.valid   = (stat == ST_RUNNABLE) && (prio != PRIO_MAX) &&
                              !(scan.has_cur && (idx == scan.cur));
            local_c.prio    = prio;
            local_c.pos     = pos;
            local_c.idx     = idx;
            local_c.live    = (stat == ST_RUNNABLE) || (stat == ST_RUNNING) ||
                              (stat == ST_DYING);
            local_c.cur_run = scan.has_cur && (idx == scan.cur) &&
                              (stat == ST_RUNNING);
        end
        tok_next = cand_merge(local_c, tok_in);
    end

    // Hand the record to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= CAND_EMPTY;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/pep_ctrl.sv]
// pep_ctrl: beat handshakes, clearing pass, scan sequencer, result
// accumulator and output register of the task picker. Depends on pep_pkg.
`timescale 1ns / 1ps

module pep_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  logic [31:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output pep_pkg::ram_wr_t wr,
    output pep_pkg::scan_t   scan,
    input  pep_pkg::cand_t   tail_tok
);
    import pep_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REDUCE = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [BANK_AW-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 smp_vld_reg, smp_vld_next;
    logic [BANK_AW-1:0]   smp_k_reg, smp_k_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 has_cur_reg, has_cur_next;
    logic [SLOT_FW-1:0]   cur_raw_reg, cur_raw_next;
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_BITS-1:0] start_reg, start_next;
    cand_t                acc_reg, acc_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [SLOT_FW-1:0]   chosen_reg, chosen_next;

    logic                 cmd;
    logic [SLOT_FW-1:0]   f_slot;
    logic [STAT_W-1:0]    f_status;
    logic [PRIO_FW-1:0]   f_prio;
    logic                 f_has_cur;
    logic [SLOT_FW-1:0]   f_cur;
    logic                 accept;
    logic                 yield_acc;
    logic                 write_acc;
    logic                 load;
    logic [SLOT_BITS-1:0] cur_red;

    // Input beat fields
    assign cmd       = s_tuser;
    assign f_slot    = s_tdata[9:0];
    assign f_status  = s_tdata[12:10];
    assign f_prio    = s_tdata[20:13];
    assign f_has_cur = s_tdata[21];
    assign f_cur     = s_tdata[31:22];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign yield_acc = accept && (cmd == CMD_YIELD);
    assign write_acc = accept && (cmd == CMD_WRITE);
    assign load      = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    assign cur_red   = SLOT_BITS'(cur_raw_reg);

    // Table writes: clearing pass hits every cell, a write beat one slot
    always_comb begin
        wr = '0;
        if (state_reg == S_CLEAR) begin
            wr.en   = 1'b1;
            wr.all  = 1'b1;
            wr.addr = k_reg;
        end else begin
            wr.en   = write_acc && (32'(f_slot) < NUM_SLOTS);
            wr.bank = f_slot[CELL_BITS-1:0];
            wr.addr = BANK_AW'(f_slot >> CELL_BITS);
            wr.word = {f_status, PRIO_BITS'(f_prio)};
        end
    end

    // Scan broadcast
    always_comb begin
        scan.rd_en   = (state_reg == S_SCAN);
        scan.rd_addr = k_reg;
        scan.smp_vld = smp_vld_reg;
        scan.smp_k   = smp_k_reg;
        scan.has_cur = has_cur_reg;
        scan.cur     = cur_reg;
        scan.start   = start_reg;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        has_cur_next = has_cur_reg;
        cur_raw_next = cur_raw_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        unique case (state_reg)
            S_CLEAR: begin
                k_next = k_reg + 1'b1;
                if (k_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (yield_acc) begin
                    has_cur_next = f_has_cur;
                    cur_raw_next = f_cur;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE: begin
                // bring the current slot into range, one subtraction a cycle
                if (32'(cur_raw_reg) < NUM_SLOTS) begin
                    cur_next = cur_red;
                    if (!has_cur_reg || (cur_red == SLOT_BITS'(NUM_SLOTS - 1))) begin
                        start_next = '0;
                    end else begin
                        start_next = cur_red + 1'b1;
                    end
                    k_next     = '0;
                    state_next = S_SCAN;
                end else begin
                    cur_raw_next = cur_raw_reg - SLOT_FW'(NUM_SLOTS);
                end
            end
            S_SCAN: begin
                k_next = k_reg + 1'b1;
                if (k_reg == BANK_AW'(BANK_DEPTH - 1)) begin
                    k_next     = '0;
                    cnt_next   = CNT_W'(DRAIN_CYCLES);
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sample tag, accumulator and output register
    always_comb begin
        smp_vld_next = (state_reg == S_SCAN);
        smp_k_next   = k_reg;
        acc_next     = yield_acc ? CAND_EMPTY : cand_merge(acc_reg, tail_tok);

        if (acc_reg.valid) begin
            act_next    = ACT_RUN;
            chosen_next = SLOT_FW'(acc_reg.idx);
        end else if (has_cur_reg && acc_reg.cur_run) begin
            act_next    = ACT_RUN;
            chosen_next = SLOT_FW'(cur_reg);
        end else if (acc_reg.live) begin
            act_next    = ACT_HALT;
            chosen_next = '0;
        end else begin
            act_next    = ACT_MONITOR;
            chosen_next = '0;
        end

        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            k_reg        <= '0;
            cnt_reg      <= '0;
            smp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            smp_vld_reg  <= smp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        smp_k_reg   <= smp_k_next;
        has_cur_reg <= has_cur_next;
        cur_raw_reg <= cur_raw_next;
        cur_reg     <= cur_next;
        start_reg   <= start_next;
        acc_reg     <= acc_next;
        if (load) begin
            act_reg    <= act_next;
            chosen_reg <= chosen_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, chosen_reg, act_reg};

endmodule

[hw/rtl/priority_env_picker.sv]
// priority_env_picker: top level of the minimum-priority task picker.
// Depends on pep_pkg, pep_ctrl, pep_cell (and pep_ram through the cells).
`timescale 1ns / 1ps

// The slot table is split over a chain of NUM_CELLS cells, each owning one
// RAM bank of BANK_DEPTH entries (slot = bank address * NUM_CELLS + cell).
// A write beat (tuser = 0) stores one slot's status and priority and gives
// no result. A yield beat (tuser = 1) reads every bank once, one entry per
// cell per cycle, while the best record ripples down the chain; the current
// slot is first reduced below NUM_SLOTS, then the banks are read, the chain
// drains and the decision is registered. The scan pace is set by the single
// read port of each cell's bank. No new beat is taken during a yield. After
// reset a clearing pass over every bank address marks every slot free; no
// beat is taken until it ends. A finished decision waits in the output
// register and is taken by m_tready while write beats are already accepted
// again.

module priority_env_picker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // cmd
    input  logic [31:0] s_tdata,   // slot[9:0], slot_status[12:10],
                                   // slot_priority[20:13], has_current[21],
                                   // current_slot[31:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // action[1:0], chosen_slot[11:2]
);
    import pep_pkg::*;

    ram_wr_t wr;
    scan_t   scan;
    cand_t   chain [NUM_CELLS+1];

    // Sequencer, accumulator and handshakes
    pep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr       (wr),
        .scan     (scan),
        .tail_tok (chain[NUM_CELLS])
    );

    // Chain of cells, head fed with an empty record
    assign chain[0] = CAND_EMPTY;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        pep_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_id (CELL_BITS'(g)),
            .wr      (wr),
            .scan    (scan),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

endmodule

[hw/rtl/pep_chk.sv]
// pep_chk: port-level checks of the task picker, bound to the top level.
// Depends on pep_pkg and priority_env_picker.
`timescale 1ns / 1ps

module pep_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import pep_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat pending after reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A yield occupies the block: no beat is taken in the next cycle
    a_yield_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_YIELD) |=> !s_tready)
        else $error("beat accepted straight after a yield");

    // A write beat never makes a result appear
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE) && !m_tvalid |=> !m_tvalid)
        else $error("result beat after a write");

endmodule

bind priority_env_picker pep_chk u_pep_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/testbench.sv]
// testbench: self-checking bench for the minimum-priority task picker.
// Drives write and yield beats, mirrors the slot table and checks every decision.
// Depends on pep_pkg and priority_env_picker.
`timescale 1ns / 1ps

module testbench;
    import pep_pkg::*;

    localparam int RANDOM_PER_PHASE = 139;
    localparam int POOL_SIZE        = 32;
    localparam int POOL_AW          = $clog2(POOL_SIZE);
    localparam int SETTLE_CYCLES    = BANK_DEPTH + NUM_CELLS + 64;
    localparam int TIMEOUT_CYCLES   = 1_000_000;

    // Status codes with no meaning to the scheduler
    localparam logic [STAT_W-1:0] ST_RSVD_5 = 3'd5;
    localparam logic [STAT_W-1:0] ST_RSVD_7 = 3'd7;

    typedef struct {
        logic               cmd;
        logic [SLOT_FW-1:0] slot;
        logic [STAT_W-1:0]  status;
        logic [PRIO_FW-1:0] prio;
        logic               has_cur;
        logic [SLOT_FW-1:0] cur;
    } task_cmd_t;

    typedef struct {
        logic [ACT_W-1:0]   action;
        logic [SLOT_FW-1:0] chosen;
    } decision_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser  = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    task_cmd_t   cmd_q[$];
    decision_t   decision_q[$];

    // Mirror of the slot table
    logic [STAT_W-1:0]    status_mirror [NUM_SLOTS];
    logic [PRIO_BITS-1:0] prio_mirror   [NUM_SLOTS];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned mismatch_count  = 0;
    int unsigned slot_pool [POOL_SIZE];

    priority_env_picker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 50 MHz clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Expected decision for a yield, from the mirrored table
    function automatic decision_t pick_next(input logic has_cur, input logic [SLOT_FW-1:0] cur);
        decision_t   d;
        int unsigned best_prio;
        int unsigned best_idx;
        int unsigned cur_idx;
        int unsigned start;
        int unsigned span;
        int unsigned idx;
        logic        live;
        best_prio = 32'(PRIO_MAX);
        best_idx  = 0;
        cur_idx   = int'(cur) % NUM_SLOTS;
        start     = has_cur ? (cur_idx + 1) % NUM_SLOTS : 0;
        span      = has_cur ? NUM_SLOTS - 1 : NUM_SLOTS;
        for (int unsigned k = 0; k < span; k++) begin
            idx = (start + k) % NUM_SLOTS;
            // strict less-than: first slot met keeps a tie
            if (status_mirror[idx[SLOT_BITS-1:0]] == ST_RUNNABLE &&
                prio_mirror[idx[SLOT_BITS-1:0]] < best_prio) begin
                best_prio = 32'(prio_mirror[idx[SLOT_BITS-1:0]]);
                best_idx  = idx;
            end
        end
        d.chosen = '0;
        if (best_prio != PRIO_MAX) begin
            d.action = ACT_RUN;
            d.chosen = best_idx[SLOT_FW-1:0];
        end else if (has_cur && status_mirror[cur_idx[SLOT_BITS-1:0]] == ST_RUNNING) begin
            d.action = ACT_RUN;
            d.chosen = cur_idx[SLOT_FW-1:0];
        end else begin
            live = 1'b0;
            for (int unsigned k = 0; k < NUM_SLOTS; k++) begin
                if (status_mirror[k[SLOT_BITS-1:0]] inside {ST_RUNNABLE, ST_RUNNING, ST_DYING})
                    live = 1'b1;
            end
            d.action = live ? ACT_HALT : ACT_MONITOR;
        end
        return d;
    endfunction

    // Update the mirror or queue a decision for one accepted beat
    function automatic void apply_beat(input logic cmd, input logic [31:0] data);
        if (cmd == CMD_WRITE) begin
            if (int'(data[9:0]) < NUM_SLOTS) begin
                status_mirror[data[9:0]] = data[12:10];
                prio_mirror[data[9:0]]   = data[20:13];
            end
        end else begin
            decision_q.push_back(pick_next(data[21], data[31:22]));
        end
    endfunction

    // Beat builders; fields the command ignores carry noise
    function automatic task_cmd_t slot_write(input int unsigned slot,
                                             input logic [STAT_W-1:0] status,
                                             input int unsigned prio);
        task_cmd_t c;
        c.cmd     = CMD_WRITE;
        c.slot    = slot[SLOT_FW-1:0];
        c.status  = status;
        c.prio    = prio[PRIO_FW-1:0];
        c.has_cur = 1'($urandom_range(1, 0));
        c.cur     = SLOT_FW'($urandom_range(NUM_SLOTS - 1, 0));
        return c;
    endfunction

    function automatic task_cmd_t yield_req(input logic has_cur, input int unsigned cur);
        task_cmd_t c;
        c.cmd     = CMD_YIELD;
        c.slot    = SLOT_FW'($urandom_range(NUM_SLOTS - 1, 0));
        c.status  = STAT_W'($urandom_range(7, 0));
        c.prio    = PRIO_FW'($urandom_range(255, 0));
        c.has_cur = has_cur;
        c.cur     = cur[SLOT_FW-1:0];
        return c;
    endfunction

    function automatic int unsigned pool_slot();
        return slot_pool[POOL_AW'($urandom_range(POOL_SIZE - 1, 0))];
    endfunction

    function automatic int unsigned rand_prio();
        case ($urandom_range(4, 0))
            0:       return 0;
            1:       return 32'(PRIO_MAX);
            2:       return $urandom_range(3, 1);
            default: return $urandom_range(255, 0);
        endcase
    endfunction

    function automatic logic [STAT_W-1:0] rand_status();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40) return ST_RUNNABLE;
        if (r < 55) return ST_RUNNING;
        if (r < 65) return ST_DYING;
        if (r < 75) return ST_FREE;
        if (r < 85) return ST_NOT_RUNNABLE;
        return STAT_W'($urandom_range(ST_RSVD_7, ST_RSVD_5));
    endfunction

    function automatic logic [STAT_W-1:0] idle_status();
        case ($urandom_range(2, 0))
            0:       return ST_FREE;
            1:       return ST_NOT_RUNNABLE;
            default: return STAT_W'($urandom_range(ST_RSVD_7, ST_RSVD_5));
        endcase
    endfunction

    // Random traffic over a small pool of slots, so yields see a busy table
    task automatic queue_random(input int n);
        int count;
        int unsigned r;
        count = 0;
        while (count < n) begin
            r = $urandom_range(99, 0);
            if (r < 2 && count > 10) begin
                // empty the pool, then probe monitor and sometimes halt
                foreach (slot_pool[i])
                    cmd_q.push_back(slot_write(slot_pool[i], idle_status(), rand_prio()));
                cmd_q.push_back(yield_req(1'($urandom_range(1, 0)),
                                          $urandom_range(NUM_SLOTS - 1, 0)));
                count += POOL_SIZE + 1;
                if ($urandom_range(1, 0)) begin
                    cmd_q.push_back(slot_write(pool_slot(), ST_DYING, rand_prio()));
                    cmd_q.push_back(yield_req(1'b1, pool_slot()));
                    count += 2;
                end
            end else if (r < 40) begin
                if ($urandom_range(99, 0) < 70)
                    cmd_q.push_back(yield_req($urandom_range(99, 0) < 75, pool_slot()));
                else
                    cmd_q.push_back(yield_req(1'($urandom_range(1, 0)),
                                              $urandom_range(NUM_SLOTS - 1, 0)));
                count++;
            end else begin
                if ($urandom_range(9, 0) != 0)
                    cmd_q.push_back(slot_write(pool_slot(), rand_status(), rand_prio()));
                else
                    cmd_q.push_back(slot_write($urandom_range(NUM_SLOTS - 1, 0),
                                               idle_status(), rand_prio()));
                count++;
            end
        end
    endtask

    // Driver: holds a beat until taken, then maybe idles
    always @(posedge aclk) begin : drive_beats
        task_cmd_t nxt;
        logic      fire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire)
                apply_beat(s_tuser, s_tdata);
            if (!s_tvalid || fire) begin
                if (cmd_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    nxt = cmd_q.pop_front();
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= {nxt.cur, nxt.has_cur, nxt.prio, nxt.status, nxt.slot};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, check each decision beat
    always @(posedge aclk) begin : check_decisions
        decision_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decision_q.size() == 0) begin
                    report_mismatch($sformatf("decision beat with none pending (tdata %h)",
                                              m_tdata));
                end else begin
                    want = decision_q.pop_front();
                    if (m_tdata[1:0] !== want.action)
                        report_mismatch($sformatf("action expected %0d got %0d",
                                                  want.action, m_tdata[1:0]));
                    if (m_tdata[11:2] !== want.chosen)
                        report_mismatch($sformatf("chosen_slot expected %0d got %0d",
                                                  want.chosen, m_tdata[11:2]));
                end
            end
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Run limit
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("testbench: errors");
        $finish;
    end

    // Stimulus and phase control
    initial begin
        int unsigned sender_pct [4];
        int unsigned recv_pct   [4];
        sender_pct = '{0, 88, 0, 13};
        recv_pct   = '{0, 0, 88, 13};
        foreach (status_mirror[i]) begin
            status_mirror[i] = ST_FREE;
            prio_mirror[i]   = '0;
        end
        slot_pool[0] = 0;    slot_pool[1] = 1;    slot_pool[2] = 3;
        slot_pool[3] = 5;    slot_pool[4] = 100;  slot_pool[5] = 101;
        slot_pool[6] = 511;  slot_pool[7] = 512;  slot_pool[8] = 1022;
        slot_pool[9] = 1023;
        for (int i = 10; i < POOL_SIZE; i++)
            slot_pool[POOL_AW'(i)] = $urandom_range(NUM_SLOTS - 1, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, dying-only, top priority, current running,
        // ties and wrap-around, unused status codes, current slot left out
        cmd_q.push_back(yield_req(1'b0, 0));
        cmd_q.push_back(yield_req(1'b1, NUM_SLOTS - 1));
        cmd_q.push_back(slot_write(5, ST_DYING, 0));
        cmd_q.push_back(yield_req(1'b0, 0));
        cmd_q.push_back(slot_write(1023, ST_RUNNABLE, PRIO_MAX));
        cmd_q.push_back(yield_req(1'b1, 5));
        cmd_q.push_back(slot_write(0, ST_RUNNING, 7));
        cmd_q.push_back(yield_req(1'b1, 0));
        cmd_q.push_back(slot_write(1023, ST_RUNNABLE, 0));
        cmd_q.push_back(slot_write(3, ST_RUNNABLE, 0));
        cmd_q.push_back(yield_req(1'b0, 0));
        cmd_q.push_back(yield_req(1'b1, 1000));
        cmd_q.push_back(yield_req(1'b1, 1023));
        cmd_q.push_back(slot_write(512, ST_RSVD_7, 0));
        cmd_q.push_back(slot_write(600, ST_RSVD_5, 128));
        cmd_q.push_back(slot_write(601, ST_RSVD_5 + 3'd1, 64));
        cmd_q.push_back(slot_write(602, ST_NOT_RUNNABLE, 0));
        cmd_q.push_back(slot_write(3, ST_FREE, 0));
        cmd_q.push_back(slot_write(1023, ST_FREE, 0));
        cmd_q.push_back(slot_write(5, ST_FREE, 0));
        cmd_q.push_back(slot_write(0, ST_FREE, 0));
        cmd_q.push_back(yield_req(1'b1, 0));
        cmd_q.push_back(slot_write(100, ST_RUNNABLE, 200));
        cmd_q.push_back(slot_write(101, ST_RUNNABLE, 100));
        cmd_q.push_back(yield_req(1'b1, 101));
        cmd_q.push_back(yield_req(1'b0, NUM_SLOTS - 1));

        // Each phase drains fully before the next: the sender holds off
        // until every decision is back
        for (int p = 0; p < 4; p++) begin
            @(negedge aclk);
            sender_idle_pct = sender_pct[p[1:0]];
            recv_stall_pct  = recv_pct[p[1:0]];
            queue_random(RANDOM_PER_PHASE);
            while (cmd_q.size() != 0 || s_tvalid || decision_q.size() != 0)
                @(negedge aclk);
        end

        // Catch any stray decision
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[priority_env_picker.f]
hw/rtl/pep_pkg.sv
hw/rtl/pep_ram.sv
hw/rtl/pep_cell.sv
hw/rtl/pep_ctrl.sv
hw/rtl/priority_env_picker.sv
hw/rtl/pep_chk.sv
tb/testbench.sv
